[rtl/ucs_pkg.sv]
package ucs_pkg;

   localparam int POS_W               = 16;
   localparam int ACC_W               = 17;
   localparam int DEFAULT_MAX_URI_LEN = 65535;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [ACC_W-1:0] PORT_SAT  = 17'd65536;
   localparam logic [ACC_W-1:0] PORT_MAX  = 17'd65535;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_char;
   } req_data_type;

   typedef struct packed {
      logic             uri_valid;
      logic [POS_W-1:0] scheme_len;
      logic [POS_W-1:0] user_start;
      logic [POS_W-1:0] user_len;
      logic [POS_W-1:0] pass_start;
      logic [POS_W-1:0] pass_len;
      logic [POS_W-1:0] host_start;
      logic [POS_W-1:0] host_len;
      logic [POS_W-1:0] port_value;
      logic [POS_W-1:0] path_start;
      logic [POS_W-1:0] path_len;
   } rsp_data_type;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_COLON,
      CLS_SLASH,
      CLS_AT,
      CLS_DIGIT
   } char_class_type;

   typedef struct packed {
      char_class_type   cls;
      logic [3:0]       digit;
      logic             last;
      logic [POS_W-1:0] pos;
      logic             overflow;
   } word_type;

endpackage

[rtl/uri_component_splitter.sv]
// URI component splitter.
// Request channel (req_valid/req_ready/req_data): one byte of URI text per word,
// with last_char set on the final byte of each URI.
// Response channel (rsp_valid/rsp_ready/rsp_data): one word per URI, issued for
// its last byte, holding the scheme length, offset and length of user, password,
// host and path, the decimal port and the uri_valid flag.
// Throughput: one byte per clock, sustained, as long as responses are taken.
// The last byte of a URI is written into the byte queue, read out by the parser
// and its response loaded into the output register; the parser updates once per
// byte and a single output register holds the finished response.
// A stalled response blocks only the next last byte; other bytes keep flowing,
// and the byte queue (QUEUE_DEPTH words) absorbs the rest until it fills, then
// req_ready drops.
// Reset clears the parser, byte position, queue and response valid; every URI
// starts from empty parts.
module uri_component_splitter import ucs_pkg::*; #(
   parameter int MAX_URI_LEN = DEFAULT_MAX_URI_LEN,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   logic     front_valid, front_ready;
   word_type front_word;
   logic     back_valid, back_ready;
   word_type back_word;

   ucs_front #(
      .MAX_URI_LEN (MAX_URI_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .word_valid (front_valid),
      .word_ready (front_ready),
      .word       (front_word)
   );

   ucs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_word  (back_word)
   );

   ucs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .word_valid (back_valid),
      .word_ready (back_ready),
      .word       (back_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/ucs_front.sv]
module ucs_front import ucs_pkg::*; #(
   parameter int MAX_URI_LEN = DEFAULT_MAX_URI_LEN
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         word_valid,
   input  logic         word_ready,
   output word_type     word
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_URI_LEN);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             accept;
   logic             overflow;
   logic [7:0]       digit_full;

   assign req_ready  = word_ready;
   assign word_valid = req_valid;
   assign accept     = req_valid & word_ready;
   assign overflow   = (pos_ff >= MAX_POS);
   assign digit_full = req_data.char_in - CHAR_ZERO;

   always_comb begin
      word.digit    = digit_full[3:0];
      word.last     = req_data.last_char;
      word.pos      = pos_ff;
      word.overflow = overflow;
      priority if (req_data.char_in == CHAR_COLON) begin
         word.cls = CLS_COLON;
      end else if (req_data.char_in == CHAR_SLASH) begin
         word.cls = CLS_SLASH;
      end else if (req_data.char_in == CHAR_AT) begin
         word.cls = CLS_AT;
      end else if (req_data.char_in >= CHAR_ZERO && req_data.char_in <= CHAR_NINE) begin
         word.cls = CLS_DIGIT;
      end else begin
         word.cls = CLS_OTHER;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_data.last_char) begin
            pos_in = '0;
         end else if (!overflow) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

[rtl/ucs_queue.sv]
module ucs_queue import ucs_pkg::*; #(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  word_type in_word,
   output logic     out_valid,
   input  logic     out_ready,
   output word_type out_word
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   word_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;
   assign out_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/ucs_back.sv]
module ucs_back import ucs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         word_valid,
   output logic         word_ready,
   input  word_type     word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   typedef enum logic [7:0] {
      MODE_SCHEME = 8'b0000_0001,
      MODE_SLASH  = 8'b0000_0010,
      MODE_USER   = 8'b0000_0100,
      MODE_PASS   = 8'b0000_1000,
      MODE_HOST   = 8'b0001_0000,
      MODE_PORT   = 8'b0010_0000,
      MODE_PATH   = 8'b0100_0000,
      MODE_DONE   = 8'b1000_0000
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] scheme_len_ff, scheme_len_in;
   logic [POS_W-1:0] user_st_ff, user_st_in, user_len_ff, user_len_in;
   logic [POS_W-1:0] pass_st_ff, pass_st_in, pass_len_ff, pass_len_in;
   logic [POS_W-1:0] host_st_ff, host_st_in, host_len_ff, host_len_in;
   logic [POS_W-1:0] path_st_ff, path_st_in, path_len_ff, path_len_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             bad_ff, bad_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;

   logic             process, emit;
   logic [POS_W-1:0] p, p1, st;
   logic [20:0]      acc_mul;
   logic [ACC_W-1:0] acc_take;
   logic             port_ok;

   assign word_ready = !word.last || !rsp_valid_ff || rsp_ready;
   assign process    = word_valid & word_ready;
   assign emit       = process & word.last;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign p        = word.pos;
   assign p1       = word.pos + 1'b1;
   assign st       = (mode_ff == MODE_SLASH) ? p : start_ff;
   assign acc_mul  = 21'({acc_ff, 3'b000}) + 21'({acc_ff, 1'b0}) + 21'(word.digit);
   assign acc_take = (acc_mul > 21'(PORT_MAX)) ? PORT_SAT : acc_mul[ACC_W-1:0];

   always_comb begin
      mode_in       = mode_ff;
      start_in      = start_ff;
      scheme_len_in = scheme_len_ff;
      user_st_in    = user_st_ff;
      user_len_in   = user_len_ff;
      pass_st_in    = pass_st_ff;
      pass_len_in   = pass_len_ff;
      host_st_in    = host_st_ff;
      host_len_in   = host_len_ff;
      path_st_in    = path_st_ff;
      path_len_in   = path_len_ff;
      acc_in        = acc_ff;
      bad_in        = bad_ff;
      err_in        = err_ff;

      if (process) begin
         if (word.overflow) begin
            err_in  = 1'b1;
            mode_in = MODE_DONE;
         end else begin
            unique case (mode_ff)
               MODE_SCHEME: begin
                  if (word.cls == CLS_COLON) begin
                     scheme_len_in = p - start_ff;
                     mode_in       = MODE_SLASH;
                  end
               end
               MODE_SLASH, MODE_USER: begin
                  if (mode_ff == MODE_SLASH) begin
                     start_in = p;
                     mode_in  = MODE_USER;
                  end
                  if (mode_ff == MODE_SLASH && word.cls == CLS_SLASH) begin
                     start_in = start_ff;
                     mode_in  = MODE_SLASH;
                  end else if (word.cls == CLS_COLON) begin
                     user_st_in  = st;
                     user_len_in = p - st;
                     start_in    = p1;
                     acc_in      = '0;
                     bad_in      = 1'b0;
                     mode_in     = MODE_PASS;
                  end else if (word.cls == CLS_AT) begin
                     user_st_in  = st;
                     user_len_in = p - st;
                     start_in    = p1;
                     mode_in     = MODE_HOST;
                  end else if (word.cls == CLS_SLASH) begin
                     host_st_in  = st;
                     host_len_in = p - st;
                     start_in    = p;
                     path_st_in  = p;
                     path_len_in = POS_W'(1);
                     mode_in     = MODE_PATH;
                  end else if (word.last) begin
                     host_st_in  = st;
                     host_len_in = p1 - st;
                     mode_in     = MODE_DONE;
                  end
               end
               MODE_PASS: begin
                  if (word.cls == CLS_AT) begin
                     pass_st_in  = start_ff;
                     pass_len_in = p - start_ff;
                     start_in    = p1;
                     acc_in      = '0;
                     bad_in      = 1'b0;
                     mode_in     = MODE_HOST;
                  end else begin
                     if (word.cls == CLS_DIGIT) begin
                        acc_in = acc_take;
                     end else if (word.cls != CLS_SLASH) begin
                        bad_in = 1'b1;
                     end
                     if (word.cls == CLS_SLASH || word.last) begin
                        host_st_in  = user_st_ff;
                        host_len_in = user_len_ff;
                        user_st_in  = '0;
                        user_len_in = '0;
                        pass_st_in  = '0;
                        pass_len_in = '0;
                        mode_in     = MODE_DONE;
                     end
                     if (word.cls == CLS_SLASH) begin
                        start_in    = p;
                        path_st_in  = p;
                        path_len_in = POS_W'(1);
                        mode_in     = MODE_PATH;
                     end
                  end
               end
               MODE_HOST: begin
                  if (word.cls == CLS_SLASH) begin
                     host_st_in  = start_ff;
                     host_len_in = p - start_ff;
                     start_in    = p;
                     path_st_in  = p;
                     path_len_in = POS_W'(1);
                     mode_in     = MODE_PATH;
                  end else if (word.cls == CLS_COLON) begin
                     host_st_in  = start_ff;
                     host_len_in = p - start_ff;
                     start_in    = p1;
                     acc_in      = '0;
                     bad_in      = 1'b0;
                     mode_in     = MODE_PORT;
                  end else if (word.last) begin
                     host_st_in  = start_ff;
                     host_len_in = p1 - start_ff;
                  end
               end
               MODE_PORT: begin
                  if (word.cls == CLS_SLASH) begin
                     start_in    = p;
                     path_st_in  = p;
                     path_len_in = POS_W'(1);
                     mode_in     = MODE_PATH;
                  end else if (word.cls == CLS_DIGIT) begin
                     acc_in = acc_take;
                  end else begin
                     err_in  = 1'b1;
                     mode_in = MODE_DONE;
                  end
               end
               MODE_PATH: begin
                  path_st_in  = start_ff;
                  path_len_in = p1 - start_ff;
               end
               default: begin
               end
            endcase
         end
      end

      port_ok                = !bad_in && (acc_in <= PORT_MAX);
      rsp_data_in.uri_valid  = (scheme_len_in != '0) && (host_len_in != '0) && port_ok && !err_in;
      rsp_data_in.scheme_len = scheme_len_in;
      rsp_data_in.user_start = user_st_in;
      rsp_data_in.user_len   = user_len_in;
      rsp_data_in.pass_start = pass_st_in;
      rsp_data_in.pass_len   = pass_len_in;
      rsp_data_in.host_start = host_st_in;
      rsp_data_in.host_len   = host_len_in;
      rsp_data_in.port_value = port_ok ? acc_in[POS_W-1:0] : '0;
      rsp_data_in.path_start = path_st_in;
      rsp_data_in.path_len   = path_len_in;

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

      if (emit) begin
         mode_in       = MODE_SCHEME;
         start_in      = '0;
         scheme_len_in = '0;
         user_st_in    = '0;
         user_len_in   = '0;
         pass_st_in    = '0;
         pass_len_in   = '0;
         host_st_in    = '0;
         host_len_in   = '0;
         path_st_in    = '0;
         path_len_in   = '0;
         acc_in        = '0;
         bad_in        = 1'b0;
         err_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SCHEME;
         start_ff      <= '0;
         scheme_len_ff <= '0;
         user_st_ff    <= '0;
         user_len_ff   <= '0;
         pass_st_ff    <= '0;
         pass_len_ff   <= '0;
         host_st_ff    <= '0;
         host_len_ff   <= '0;
         path_st_ff    <= '0;
         path_len_ff   <= '0;
         acc_ff        <= '0;
         bad_ff        <= 1'b0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         start_ff      <= start_in;
         scheme_len_ff <= scheme_len_in;
         user_st_ff    <= user_st_in;
         user_len_ff   <= user_len_in;
         pass_st_ff    <= pass_st_in;
         pass_len_ff   <= pass_len_in;
         host_st_ff    <= host_st_in;
         host_len_ff   <= host_len_in;
         path_st_ff    <= path_st_in;
         path_len_ff   <= path_len_in;
         acc_ff        <= acc_in;
         bad_ff        <= bad_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

[rtl/ucs_checker.sv]
module ucs_checker import ucs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");

   a_valid_parts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.uri_valid |->
         rsp_data.scheme_len != '0 && rsp_data.host_len != '0)
      else $error("valid URI without scheme or host");

   a_path_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.path_len == '0 |-> rsp_data.path_start == '0)
      else $error("empty path with nonzero offset");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind uri_component_splitter ucs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
